### hw/rtl/md4_pkg.sv
package md4_pkg;

    localparam logic [31:0] K_ROUND2 = 32'h5a827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam int unsigned NUM_WORDS = 16;
    localparam logic [5:0]  LAST_ROUND_STEP = 6'd47;
    localparam logic [5:0]  LEN_POS_LIMIT   = 6'd56;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_APPEND,
        OP_PAD,
        OP_ZERO,
        OP_LEN,
        OP_LOAD,
        OP_ROUND,
        OP_ADD,
        OP_EMIT,
        OP_INIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_LEFT_ZERO,
        C_NOT_FULL,
        C_NOT_LAST,
        C_POS_LT56,
        C_ROUND_MORE,
        C_EMIT_MORE
    } cond_t;

    typedef struct packed {
        op_t        op;
        cond_t      cond;
        logic       call;
        logic       ret;
        logic [3:0] target;
    } uword_t;

    typedef struct packed {
        logic in_fire;
        logic out_fire;
        logic left_zero;
        logic pos_full;
        logic pos_lt56;
        logic last;
        logic round_last;
        logic idx_last;
    } status_t;

    // Microprogram addresses.
    localparam logic [3:0] A_WAIT     = 4'd0;
    localparam logic [3:0] A_SCAN     = 4'd1;
    localparam logic [3:0] A_APPEND   = 4'd2;
    localparam logic [3:0] A_FULL     = 4'd3;
    localparam logic [3:0] A_RESUME   = 4'd4;
    localparam logic [3:0] A_CHECK    = 4'd5;
    localparam logic [3:0] A_PAD      = 4'd6;
    localparam logic [3:0] A_XCOMP    = 4'd7;
    localparam logic [3:0] A_ZERO     = 4'd8;
    localparam logic [3:0] A_LEN      = 4'd9;
    localparam logic [3:0] A_FCOMP    = 4'd10;
    localparam logic [3:0] A_EMIT     = 4'd11;
    localparam logic [3:0] A_INIT     = 4'd12;
    localparam logic [3:0] A_LOAD     = 4'd13;
    localparam logic [3:0] A_ROUND    = 4'd14;
    localparam logic [3:0] A_ADD      = 4'd15;

    function automatic uword_t ucode_rom(input logic [3:0] addr);
        uword_t w;
        unique case (addr)
            A_WAIT:   w = '{OP_WAIT,   C_NO_IN,      1'b0, 1'b0, A_WAIT};
            A_SCAN:   w = '{OP_NOP,    C_LEFT_ZERO,  1'b0, 1'b0, A_CHECK};
            A_APPEND: w = '{OP_APPEND, C_NOT_FULL,   1'b0, 1'b0, A_SCAN};
            A_FULL:   w = '{OP_NOP,    C_ALWAYS,     1'b1, 1'b0, A_LOAD};
            A_RESUME: w = '{OP_NOP,    C_ALWAYS,     1'b0, 1'b0, A_SCAN};
            A_CHECK:  w = '{OP_NOP,    C_NOT_LAST,   1'b0, 1'b0, A_WAIT};
            A_PAD:    w = '{OP_PAD,    C_POS_LT56,   1'b0, 1'b0, A_LEN};
            A_XCOMP:  w = '{OP_NOP,    C_ALWAYS,     1'b1, 1'b0, A_LOAD};
            A_ZERO:   w = '{OP_ZERO,   C_NEVER,      1'b0, 1'b0, A_WAIT};
            A_LEN:    w = '{OP_LEN,    C_NEVER,      1'b0, 1'b0, A_WAIT};
            A_FCOMP:  w = '{OP_NOP,    C_ALWAYS,     1'b1, 1'b0, A_LOAD};
            A_EMIT:   w = '{OP_EMIT,   C_EMIT_MORE,  1'b0, 1'b0, A_EMIT};
            A_INIT:   w = '{OP_INIT,   C_ALWAYS,     1'b0, 1'b0, A_WAIT};
            A_LOAD:   w = '{OP_LOAD,   C_NEVER,      1'b0, 1'b0, A_WAIT};
            A_ROUND:  w = '{OP_ROUND,  C_ROUND_MORE, 1'b0, 1'b0, A_ROUND};
            A_ADD:    w = '{OP_ADD,    C_NEVER,      1'b0, 1'b1, A_WAIT};
            default:  w = '{OP_NOP,    C_ALWAYS,     1'b0, 1'b0, A_WAIT};
        endcase
        return w;
    endfunction

    // Message word used by a compression step.
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] j;
        logic [3:0] idx;
        j = step[3:0];
        case (step[5:4])
            2'd0:    idx = j;
            2'd1:    idx = {j[1:0], j[3:2]};
            default: idx = {j[0], j[1], j[2], j[3]};
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] s;
        case ({step[5:4], step[1:0]})
            4'b00_00: s = 5'd3;
            4'b00_01: s = 5'd7;
            4'b00_10: s = 5'd11;
            4'b00_11: s = 5'd19;
            4'b01_00: s = 5'd3;
            4'b01_01: s = 5'd5;
            4'b01_10: s = 5'd9;
            4'b01_11: s = 5'd13;
            4'b10_00: s = 5'd3;
            4'b10_01: s = 5'd9;
            4'b10_10: s = 5'd11;
            default:  s = 5'd15;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/md4_message_digest.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   data_word, byte_count, end_of_message
// out      output     out_valid / out_ready digest_word, word_index, last_word
//
// An input transaction is taken in the wait state; each valid byte then passes
// through scan and append, and the end-of-item check through scan and check.
// Every 64th byte starts a compression (48 rounds on one shared step unit,
// plus load, chain add, call and return), run from the microcode.
// The final transaction adds padding, one or two compressions, one digest word
// per cycle while out_ready is high, and a return to the initial chain value.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output transaction holds the sequencer in place; no input is
// taken until the fourth digest word has been delivered.
module md4_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import md4_pkg::*;

    uword_t  uword;
    status_t status;

    // The sequencer steps through the microprogram; the datapath holds the
    // chain value, the block buffer, the byte total and the working set.
    md4_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    md4_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .uword          (uword),
        .status         (status),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    // Input and output are never open at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    // The digest always starts with word a.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 2'd0))
        else $error("digest does not start at word a");

    // After the last digest word, the init step restores the chain, and then the
    // block waits for the next message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> !in_ready ##1 in_ready)
        else $error("no return to idle after digest");

endmodule

### hw/rtl/md4_seq.sv
module md4_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  md4_pkg::status_t  status,
    output md4_pkg::uword_t   uword
);
    import md4_pkg::*;

    logic [3:0] upc_reg;
    logic [3:0] upc_next;
    logic [3:0] ret_reg;
    logic [3:0] ret_next;
    logic       taken;

    assign uword = ucode_rom(upc_reg);

    always_comb
    begin
        case (uword.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_IN:      taken = !status.in_fire;
            C_LEFT_ZERO:  taken = status.left_zero;
            C_NOT_FULL:   taken = !status.pos_full;
            C_NOT_LAST:   taken = !status.last;
            C_POS_LT56:   taken = status.pos_lt56;
            C_ROUND_MORE: taken = !status.round_last;
            C_EMIT_MORE:  taken = !(status.out_fire && status.idx_last);
            default:      taken = 1'b0;
        endcase
    end

    always_comb
    begin
        ret_next = ret_reg;
        if (uword.ret)
        begin
            upc_next = ret_reg;
        end
        else if (taken)
        begin
            upc_next = uword.target;
            if (uword.call)
            begin
                ret_next = upc_reg + 4'd1;
            end
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_WAIT;
            ret_reg <= A_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

### hw/rtl/md4_dp.sv
module md4_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  md4_pkg::uword_t   uword,
    output md4_pkg::status_t  status,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       data_word,
    input  logic [2:0]        byte_count,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       digest_word,
    output logic [1:0]        word_index,
    output logic              last_word
);
    import md4_pkg::*;

    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] work_reg [4];
    logic [31:0] work_next [4];
    logic [31:0] blk_reg [NUM_WORDS];
    logic [31:0] blk_next [NUM_WORDS];
    logic [60:0] total_reg;
    logic [60:0] total_next;
    logic [31:0] hold_reg;
    logic [31:0] hold_next;
    logic [2:0]  left_reg;
    logic [2:0]  left_next;
    logic        last_reg;
    logic        last_next;
    logic [5:0]  step_reg;
    logic [5:0]  step_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;

    logic        in_fire;
    logic        out_fire;
    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [31:0] fx;
    logic [31:0] kx;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;

    assign in_ready    = (uword.op == OP_WAIT);
    assign out_valid   = (uword.op == OP_EMIT);
    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid && out_ready;
    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);

    assign pos     = total_reg[5:0];
    assign bit_len = {total_reg, 3'b000};

    assign status.in_fire    = in_fire;
    assign status.out_fire   = out_fire;
    assign status.left_zero  = (left_reg == 3'd0);
    assign status.pos_full   = (pos == 6'd63);
    assign status.pos_lt56   = (pos < LEN_POS_LIMIT);
    assign status.last       = last_reg;
    assign status.round_last = (step_reg == LAST_ROUND_STEP);
    assign status.idx_last   = (idx_reg == 2'd3);

    // One compression step on the rotating working set a, b, c, d.
    assign x = work_reg[1];
    assign y = work_reg[2];
    assign z = work_reg[3];

    always_comb
    begin
        case (step_reg[5:4])
            2'd0:
            begin
                fx = (x & y) | (~x & z);
                kx = 32'd0;
            end
            2'd1:
            begin
                fx = (x & y) | (x & z) | (y & z);
                kx = K_ROUND2;
            end
            default:
            begin
                fx = x ^ y ^ z;
                kx = K_ROUND3;
            end
        endcase
    end

    assign sum      = work_reg[0] + fx + blk_reg[msg_index(step_reg)] + kx;
    assign rot_wide = {32'd0, sum} << rot_amount(step_reg);

    always_comb
    begin
        chain_next = chain_reg;
        work_next  = work_reg;
        blk_next   = blk_reg;
        total_next = total_reg;
        hold_next  = hold_reg;
        left_next  = left_reg;
        last_next  = last_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;

        unique case (uword.op)
            OP_NOP:
            begin
            end
            OP_WAIT:
            begin
                if (in_fire)
                begin
                    hold_next = data_word;
                    left_next = (byte_count > 3'd4) ? 3'd4 : byte_count;
                    last_next = end_of_message;
                end
            end
            OP_APPEND:
            begin
                blk_next[pos[5:2]][{pos[1:0], 3'b000} +: 8] = hold_reg[7:0];
                hold_next  = {8'd0, hold_reg[31:8]};
                left_next  = left_reg - 3'd1;
                total_next = total_reg + 61'd1;
            end
            OP_PAD:
            begin
                for (int w = 0; w < NUM_WORDS; w++)
                begin
                    if (4'(w) == pos[5:2])
                    begin
                        for (int l = 0; l < 4; l++)
                        begin
                            if (2'(l) == pos[1:0])
                            begin
                                blk_next[w][8*l +: 8] = PAD_BYTE;
                            end
                            else if (2'(l) > pos[1:0])
                            begin
                                blk_next[w][8*l +: 8] = 8'd0;
                            end
                        end
                    end
                    else if (4'(w) > pos[5:2])
                    begin
                        blk_next[w] = 32'd0;
                    end
                end
            end
            OP_ZERO:
            begin
                for (int w = 0; w < NUM_WORDS; w++)
                begin
                    blk_next[w] = 32'd0;
                end
            end
            OP_LEN:
            begin
                blk_next[14] = bit_len[31:0];
                blk_next[15] = bit_len[63:32];
            end
            OP_LOAD:
            begin
                work_next = chain_reg;
                step_next = 6'd0;
            end
            OP_ROUND:
            begin
                // The updated register moves to position one, so the next
                // step always updates position zero.
                work_next[0] = work_reg[3];
                work_next[1] = rot_wide[31:0] | rot_wide[63:32];
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                step_next    = step_reg + 6'd1;
            end
            OP_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
            end
            OP_EMIT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            OP_INIT:
            begin
                chain_next[0] = INIT_A;
                chain_next[1] = INIT_B;
                chain_next[2] = INIT_C;
                chain_next[3] = INIT_D;
                total_next    = 61'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
            total_reg    <= 61'd0;
            left_reg     <= 3'd0;
            last_reg     <= 1'b0;
            step_reg     <= 6'd0;
            idx_reg      <= 2'd0;
        end
        else
        begin
            chain_reg <= chain_next;
            total_reg <= total_next;
            left_reg  <= left_next;
            last_reg  <= last_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        blk_reg  <= blk_next;
        hold_reg <= hold_next;
    end

endmodule
